// ----- hdl/rc_pkg.sv -----
// rc_pkg: shared types, codes and constants of the radix converter
// no dependencies; imported by rc_ctrl, rc_datapath and radix_converter_core

package rc_pkg;

	// field widths
	localparam int ValueW  = 31;
	localparam int RadixW  = 4;
	localparam int ResultW = 63;
	localparam int StatusW = 2;
	localparam int DigitW  = 4;

	// a 31-bit value has at most 31 digits in base 2
	localparam int MaxDigits = ValueW;
	localparam int CntW      = $clog2(MaxDigits + 1);

	// reciprocal estimate: q = (v * recip) >> RecipShift, then one correction
	localparam int RecipW     = 32;
	localparam int RecipShift = 32;
	localparam int ProdW      = ValueW + RecipW;

	localparam logic [RadixW-1:0]  RadixMin = 4'd2;
	localparam logic [RadixW-1:0]  RadixMax = 4'd10;
	localparam logic [RadixW-1:0]  RadixDec = 4'd10;
	localparam logic [ResultW-1:0] ResultMax = {ResultW{1'b1}};

	// action codes
	localparam logic MODE_TO_BASE   = 1'b0;
	localparam logic MODE_FROM_BASE = 1'b1;

	// status codes
	localparam logic [StatusW-1:0] ST_OK   = 2'd0;
	localparam logic [StatusW-1:0] ST_BASE = 2'd1;
	localparam logic [StatusW-1:0] ST_OVF  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mul;
		logic fix;
		logic pack;
		logic finish;
	} rc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic v_zero;
		logic stk_empty;
		logic bad;
	} rc_stat_t;

	// floor(2^32 / b) for the valid bases
	function automatic logic [RecipW-1:0] rc_recip(input logic [RadixW-1:0] b);
		logic [RecipW-1:0] r;
		case (b)
			4'd2:    r = 32'h8000_0000;
			4'd3:    r = 32'h5555_5555;
			4'd4:    r = 32'h4000_0000;
			4'd5:    r = 32'h3333_3333;
			4'd6:    r = 32'h2AAA_AAAA;
			4'd7:    r = 32'h2492_4924;
			4'd8:    r = 32'h2000_0000;
			4'd9:    r = 32'h1C71_C71C;
			4'd10:   r = 32'h1999_9999;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/radix_converter_core.sv -----
// radix_converter_core: top level of the radix converter
// depends on rc_pkg, rc_ctrl and rc_datapath

// usage
//   slave stream: s_tuser carries the action, s_tdata the value and radix
//   master stream: m_tdata carries the result, m_tuser the status code
//   action 0 writes value in base radix, digits packed as decimal digits
//   action 1 reads the decimal digits of value as base-radix digits
//   radix outside 2..10 gives result 0, status 1; mode 0 overflow of the
//   packed digits saturates to 2^63-1 with status 2
// sequencing
//   one item at a time; s_tready is high only while idle, so the next item
//   is accepted only once the last has moved to the output register; each
//   digit (base-radix digits in mode 0, decimal digits in mode 1) takes a
//   reciprocal multiply step and a correction step, then the digits are
//   popped and packed one per packing step, then the result is finished;
//   a bad radix or zero value skips extraction and packing
// reset and stall
//   arst_n clears the controller, the digit count and the output valid
//   the result sits in an output register, so the next item is accepted
//   while it waits; a finished item waits in place while m_tready is low

module radix_converter_core
	import rc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value [30:0], radix [34:31], zero [39:35]
	input  logic        s_tuser,   // action [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // result [62:0], zero [63]
	output logic [1:0]  m_tuser    // status [1:0]
);

	rc_cmd_t             cmd;
	rc_stat_t            stat;
	logic [ResultW-1:0]  result;
	logic [StatusW-1:0]  status;

	// sequencing and output handshake
	rc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// divider, digit stack, packer and result register
	rc_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.action (s_tuser),
		.value  (s_tdata[ValueW-1:0]),
		.radix  (s_tdata[ValueW +: RadixW]),
		.result (result),
		.status (status)
	);

	assign m_tdata = {1'b0, result};
	assign m_tuser = status;

endmodule

// ----- hdl/rc_datapath.sv -----
// rc_datapath: digit extraction by reciprocal multiply, digit stack and packing
// accumulator, output payload register; depends on rc_pkg

module rc_datapath
	import rc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  rc_cmd_t             cmd,
	output rc_stat_t            stat,
	input  logic                action,
	input  logic [ValueW-1:0]   value,
	input  logic [RadixW-1:0]   radix,
	output logic [ResultW-1:0]  result,
	output logic [StatusW-1:0]  status
);

	logic                mode_q;
	logic [RadixW-1:0]   radix_q;
	logic                bad_q;
	logic                ovf_q;
	logic [ValueW-1:0]   v_q;
	logic [ProdW-1:0]    prod_s1;
	logic [DigitW-1:0]   stk_q [MaxDigits];
	logic [CntW-1:0]     cnt_q;
	logic [ResultW-1:0]  acc_q;
	logic [ResultW-1:0]  result_q;
	logic [StatusW-1:0]  status_q;

	logic [RadixW-1:0]   divisor;
	logic [RecipW-1:0]   recip;
	logic [ValueW-1:0]   q_est;
	logic [ValueW+3:0]   qb;
	logic [ValueW+3:0]   rem;
	logic [4:0]          rem5;
	logic                fix_up;
	logic [DigitW-1:0]   digit;
	logic [DigitW-1:0]   top_d;
	logic [ResultW+3:0]  wide_dec;
	logic [38:0]         wide_rad;
	logic                radix_ok;

	// mode 0 divides by the base, mode 1 peels decimal digits
	assign divisor = (mode_q == MODE_FROM_BASE) ? RadixDec : radix_q;
	assign recip   = rc_recip(divisor);

	// estimate is at most one low: remainder lands below twice the divisor
	assign q_est  = prod_s1[RecipShift +: ValueW];
	assign qb     = (ValueW+4)'(q_est) * (ValueW+4)'(divisor);
	assign rem    = (ValueW+4)'(v_q) - qb;
	assign rem5   = rem[4:0];
	assign fix_up = (rem5 >= 5'(divisor));
	assign digit  = fix_up ? 4'(rem5 - 5'(divisor)) : rem5[3:0];

	// packing: most significant digit first
	assign top_d    = stk_q[0];
	assign wide_dec = ((ResultW+4)'(acc_q) << 3) + ((ResultW+4)'(acc_q) << 1)
	                + (ResultW+4)'(top_d);
	assign wide_rad = 39'(acc_q[34:0]) * 39'(radix_q) + 39'(top_d);

	assign radix_ok = radix inside {[RadixMin:RadixMax]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.fix) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.pack) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= action;
			radix_q <= radix;
			bad_q   <= !radix_ok;
			ovf_q   <= 1'b0;
			v_q     <= value;
			acc_q   <= '0;
		end
		if (cmd.mul) begin
			prod_s1 <= ProdW'(v_q) * ProdW'(recip);
		end
		if (cmd.fix) begin
			v_q      <= q_est + ValueW'(fix_up);
			stk_q[0] <= digit;
			for (int i = 1; i < MaxDigits; i++) begin
				stk_q[i] <= stk_q[i-1];
			end
		end
		if (cmd.pack) begin
			for (int i = 0; i < MaxDigits - 1; i++) begin
				stk_q[i] <= stk_q[i+1];
			end
			if (mode_q == MODE_TO_BASE) begin
				acc_q <= wide_dec[ResultW-1:0];
				if (wide_dec[ResultW+3:ResultW] != 4'd0) begin
					ovf_q <= 1'b1;
				end
			end else begin
				acc_q <= ResultW'(wide_rad);
			end
		end
		if (cmd.finish) begin
			if (bad_q) begin
				result_q <= '0;
				status_q <= ST_BASE;
			end else if (ovf_q) begin
				result_q <= ResultMax;
				status_q <= ST_OVF;
			end else begin
				result_q <= acc_q;
				status_q <= ST_OK;
			end
		end
	end

	assign stat.v_zero    = (v_q == '0);
	assign stat.stk_empty = (cnt_q == '0);
	assign stat.bad       = bad_q;

	assign result = result_q;
	assign status = status_q;

	// corrected digit is a proper digit of the divisor
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fix |-> (digit < divisor))
		else $error("extracted digit not below divisor");

	// stack never overfills
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fix |-> (cnt_q < CntW'(MaxDigits)))
		else $error("digit stack overflow");

	// never pops an empty stack
	a_pop_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pack |-> (cnt_q != '0))
		else $error("digit stack underflow");

endmodule

// ----- hdl/rc_ctrl.sv -----
// rc_ctrl: sequencing state machine and output valid flag
// depends on rc_pkg; drives rc_datapath through rc_cmd_t

module rc_ctrl
	import rc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  rc_stat_t stat,
	output rc_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_FIX  = 5'b00100,
		S_PACK = 5'b01000,
		S_DONE = 5'b10000
	} rc_state_t;

	rc_state_t state_q, state_d;
	logic      out_valid_q;
	logic      out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				if (stat.bad || stat.v_zero) begin
					state_d = S_PACK;
				end else begin
					cmd.mul = 1'b1;
					state_d = S_FIX;
				end
			end
			S_FIX: begin
				cmd.fix = 1'b1;
				state_d = S_MUL;
			end
			S_PACK: begin
				if (stat.stk_empty) begin
					state_d = S_DONE;
				end else begin
					cmd.pack = 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

	// output register is only overwritten once its item has left
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || m_tready))
		else $error("result overwritten while pending");

	// an accepted item starts extraction next cycle
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_MUL))
		else $error("accepted item not started");

	// a result appears only after a finish command
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("result valid without finish");

endmodule
